// File: hdl/bupab_pkg.sv
`default_nettype none

package bupab_pkg;

  localparam int MAX_SMALL_WIDTH_DEF  = 64;
  localparam int MAX_SMALL_HEIGHT_DEF = 64;
  localparam int MAX_LARGE_DIM_DEF    = 1024;

  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int PIX_W    = NUM_CH * CH_W;
  localparam int RATIO_W  = 9;
  localparam int SDIM_W   = 7;
  localparam int LDIM_W   = 11;
  localparam int STEP_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int OPA_W    = 24;
  localparam int OPB_W    = 17;
  localparam int ACC_W    = 40;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [STEP_W-1:0]  Q16_ONE    = 17'h10000;
  localparam logic [RATIO_W-1:0] RATIO_FULL = 9'd256;

  localparam logic [REG_IDX_W-1:0] REG_BLEND_RATIO    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SMALL_IS_FIRST = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SMALL_WIDTH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SMALL_HEIGHT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LARGE_WIDTH    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LARGE_HEIGHT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_X_STEP         = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_Y_STEP         = 3'd7;

  localparam logic [RATIO_W-1:0] BLEND_RATIO_RST = 9'd128;
  localparam logic [SDIM_W-1:0]  SMALL_DIM_RST   = 7'd64;
  localparam logic [LDIM_W-1:0]  LARGE_DIM_RST   = 11'd64;
  localparam logic [STEP_W-1:0]  STEP_RST        = 17'h10000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BLEND = 1'b1;

endpackage

`default_nettype wire

// File: hdl/bilinear_upscale_alpha_blend.sv
// Bilinear upscale and alpha blend, RGB888.
// Input channel (in_valid/in_stall): operation 0 writes the next pixel of the
// small image into the internal store (raster order, wraps after the last
// pixel); operation 1 takes the next pixel of the large image in raster order.
// Each blend item samples the stored image bilinearly at the Q16 position
// (column*x_step, row*y_step), blends it with the pixel by blend_ratio and
// yields one output item (out_valid/out_stall) with end_of_image on the last
// pixel. Load items give no output.
// A blend item holds in_stall until its result is loaded into the output
// register, so no new item is taken while a blend is in progress. The work
// is done on one shared 24x17 multiply-accumulate unit (2 position products,
// 2 row-base products, 18 interpolation and 6 blend products) and four reads
// of the single-port image store.
// A stalled result waits in the output register; new items are still taken
// while the sequencer is idle, and a finished blend waits until the register is free.
// Reset (rst, synchronous) sets the registers to their defaults and clears the
// load address and output position; the image store is not cleared.
// Registers are written over the APB port, one word each at 4*index.
`default_nettype none

module bilinear_upscale_alpha_blend #(
  parameter int MAX_SMALL_WIDTH  = bupab_pkg::MAX_SMALL_WIDTH_DEF,
  parameter int MAX_SMALL_HEIGHT = bupab_pkg::MAX_SMALL_HEIGHT_DEF,
  parameter int MAX_LARGE_DIM    = bupab_pkg::MAX_LARGE_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bupab_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bupab_pkg::PDATA_W-1:0]    pwdata,
  output logic      [bupab_pkg::PDATA_W-1:0]    prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             operation,
  input  wire logic [bupab_pkg::CH_W-1:0]       in_blue,
  input  wire logic [bupab_pkg::CH_W-1:0]       in_green,
  input  wire logic [bupab_pkg::CH_W-1:0]       in_red,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [bupab_pkg::CH_W-1:0]       out_blue,
  output logic      [bupab_pkg::CH_W-1:0]       out_green,
  output logic      [bupab_pkg::CH_W-1:0]       out_red,
  output logic                                  end_of_image
);

  import bupab_pkg::*;

  localparam int STORE_DEPTH = MAX_SMALL_WIDTH * MAX_SMALL_HEIGHT;
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int XW  = $clog2(MAX_SMALL_WIDTH);
  localparam int YW  = $clog2(MAX_SMALL_HEIGHT);
  localparam int SWW = $clog2(MAX_SMALL_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SMALL_HEIGHT + 1);
  localparam int CW  = $clog2(MAX_LARGE_DIM);
  localparam int LW  = $clog2(MAX_LARGE_DIM + 1);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SX   = 5'd1;
  localparam logic [4:0] ST_SY   = 5'd2;
  localparam logic [4:0] ST_YL   = 5'd3;
  localparam logic [4:0] ST_B1   = 5'd4;
  localparam logic [4:0] ST_B2   = 5'd5;
  localparam logic [4:0] ST_B3   = 5'd6;
  localparam logic [4:0] ST_R1   = 5'd7;
  localparam logic [4:0] ST_R2   = 5'd8;
  localparam logic [4:0] ST_R3   = 5'd9;
  localparam logic [4:0] ST_R4   = 5'd10;
  localparam logic [4:0] ST_M1   = 5'd11;
  localparam logic [4:0] ST_M2   = 5'd12;
  localparam logic [4:0] ST_M3   = 5'd13;
  localparam logic [4:0] ST_M4   = 5'd14;
  localparam logic [4:0] ST_M5   = 5'd15;
  localparam logic [4:0] ST_M6   = 5'd16;
  localparam logic [4:0] ST_BL1  = 5'd17;
  localparam logic [4:0] ST_BL2  = 5'd18;
  localparam logic [4:0] ST_BL3  = 5'd19;
  localparam logic [4:0] ST_DONE = 5'd20;

  // configuration
  logic [RATIO_W-1:0] blend_ratio;
  logic               small_is_first;
  logic [SDIM_W-1:0]  small_width;
  logic [SDIM_W-1:0]  small_height;
  logic [LDIM_W-1:0]  large_width;
  logic [LDIM_W-1:0]  large_height;
  logic [STEP_W-1:0]  x_step;
  logic [STEP_W-1:0]  y_step;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  // control and datapath
  logic [4:0]          state;
  logic [AW-1:0]       load_address;
  logic [CW-1:0]       out_column;
  logic [CW-1:0]       out_row;
  logic [PIX_W-1:0]    mem [STORE_DEPTH];
  logic [PIX_W-1:0]    rdata;
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  logic [PIX_W-1:0]    stream_pix;
  logic [PIX_W-1:0]    pix [4];
  logic [XW-1:0]       x1;
  logic [XW-1:0]       x2;
  logic [YW-1:0]       y1;
  logic [YW-1:0]       y2;
  logic [FRAC_W-1:0]   fx;
  logic [FRAC_W-1:0]   fy;
  logic [AW-1:0]       base1;
  logic [AW-1:0]       base2;
  logic [OPA_W-1:0]    top;
  logic [OPA_W-1:0]    bot;
  logic [CH_W-1:0]     sample;
  logic [1:0]          ch;
  logic [CH_W-1:0]     res [NUM_CH];
  logic [ACC_W-1:0]    acc;

  // derived
  logic [SWW-1:0]      sw;
  logic [SWW-1:0]      sw_m1;
  logic [SHW-1:0]      sh;
  logic [SHW-1:0]      sh_m1;
  logic [LW-1:0]       lw;
  logic [LW-1:0]       lh;
  logic [STEP_W-1:0]   xs;
  logic [STEP_W-1:0]   ys;
  logic [RATIO_W-1:0]  ratio;
  logic [RATIO_W-1:0]  ratio_inv;
  logic [STEP_W-1:0]   wx0;
  logic [STEP_W-1:0]   wy0;
  logic [CW-1:0]       ipos;
  logic [XW-1:0]       x1_c;
  logic [XW:0]         x1_inc;
  logic [XW-1:0]       x2_c;
  logic [YW-1:0]       y1_c;
  logic [YW:0]         y1_inc;
  logic [YW-1:0]       y2_c;
  logic [CH_W-1:0]     stream_ch;
  logic [CH_W-1:0]     acc_byte;
  logic [OPA_W-1:0]    op_a;
  logic [OPB_W-1:0]    op_b;
  logic [OPA_W+OPB_W-1:0] product;
  logic                acc_load;
  logic                acc_add;
  logic [ACC_W-1:0]    acc_next;
  logic [AW:0]         load_inc;
  logic                last_col;
  logic                last_row;
  logic                in_take;
  logic                out_load;

  // APB
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_ratio    <= BLEND_RATIO_RST;
      small_is_first <= 1'b1;
      small_width    <= SMALL_DIM_RST;
      small_height   <= SMALL_DIM_RST;
      large_width    <= LARGE_DIM_RST;
      large_height   <= LARGE_DIM_RST;
      x_step         <= STEP_RST;
      y_step         <= STEP_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_BLEND_RATIO:    blend_ratio    <= pwdata[RATIO_W-1:0];
        REG_SMALL_IS_FIRST: small_is_first <= pwdata[0];
        REG_SMALL_WIDTH:    small_width    <= pwdata[SDIM_W-1:0];
        REG_SMALL_HEIGHT:   small_height   <= pwdata[SDIM_W-1:0];
        REG_LARGE_WIDTH:    large_width    <= pwdata[LDIM_W-1:0];
        REG_LARGE_HEIGHT:   large_height   <= pwdata[LDIM_W-1:0];
        REG_X_STEP:         x_step         <= pwdata[STEP_W-1:0];
        REG_Y_STEP:         y_step         <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLEND_RATIO:    prdata = PDATA_W'(blend_ratio);
      REG_SMALL_IS_FIRST: prdata = PDATA_W'(small_is_first);
      REG_SMALL_WIDTH:    prdata = PDATA_W'(small_width);
      REG_SMALL_HEIGHT:   prdata = PDATA_W'(small_height);
      REG_LARGE_WIDTH:    prdata = PDATA_W'(large_width);
      REG_LARGE_HEIGHT:   prdata = PDATA_W'(large_height);
      REG_X_STEP:         prdata = PDATA_W'(x_step);
      REG_Y_STEP:         prdata = PDATA_W'(y_step);
      default:            prdata = '0;
    endcase
  end

  // clamped settings
  assign sw = (small_width == '0) ? SWW'(1) :
              (32'(small_width) > MAX_SMALL_WIDTH) ? SWW'(MAX_SMALL_WIDTH) : SWW'(small_width);
  assign sh = (small_height == '0) ? SHW'(1) :
              (32'(small_height) > MAX_SMALL_HEIGHT) ? SHW'(MAX_SMALL_HEIGHT) :
              SHW'(small_height);
  assign lw = (large_width == '0) ? LW'(1) :
              (32'(large_width) > MAX_LARGE_DIM) ? LW'(MAX_LARGE_DIM) : LW'(large_width);
  assign lh = (large_height == '0) ? LW'(1) :
              (32'(large_height) > MAX_LARGE_DIM) ? LW'(MAX_LARGE_DIM) : LW'(large_height);
  assign sw_m1     = sw - 1'b1;
  assign sh_m1     = sh - 1'b1;
  assign xs        = (x_step > Q16_ONE) ? Q16_ONE : x_step;
  assign ys        = (y_step > Q16_ONE) ? Q16_ONE : y_step;
  assign ratio     = (blend_ratio > RATIO_FULL) ? RATIO_FULL : blend_ratio;
  assign ratio_inv = RATIO_FULL - ratio;
  assign wx0       = Q16_ONE - {1'b0, fx};
  assign wy0       = Q16_ONE - {1'b0, fy};

  // neighbour indexes from the Q16 position held in acc
  assign ipos   = acc[FRAC_W +: CW];
  assign x1_c   = (ipos > sw_m1) ? XW'(sw_m1) : XW'(ipos);
  assign x1_inc = {1'b0, x1_c} + 1'b1;
  assign x2_c   = (x1_inc > sw_m1) ? XW'(sw_m1) : XW'(x1_inc);
  assign y1_c   = (ipos > sh_m1) ? YW'(sh_m1) : YW'(ipos);
  assign y1_inc = {1'b0, y1_c} + 1'b1;
  assign y2_c   = (y1_inc > sh_m1) ? YW'(sh_m1) : YW'(y1_inc);

  assign stream_ch = stream_pix[{ch, 3'b000} +: CH_W];
  assign acc_byte  = acc[2*FRAC_W +: CH_W];

  // shared multiply-accumulate unit
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    acc_load = 1'b0;
    acc_add  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        op_a = OPA_W'(sw);
        op_b = OPB_W'(sh);
      end
      ST_SX: begin
        op_a = OPA_W'(out_column); op_b = xs; acc_load = 1'b1;
      end
      ST_SY: begin
        op_a = OPA_W'(out_row); op_b = ys; acc_load = 1'b1;
      end
      ST_B1: begin
        op_a = OPA_W'(y1); op_b = OPB_W'(sw); acc_load = 1'b1;
      end
      ST_B2: begin
        op_a = OPA_W'(y2); op_b = OPB_W'(sw); acc_load = 1'b1;
      end
      ST_M1: begin
        op_a = OPA_W'(pix[0][{ch, 3'b000} +: CH_W]); op_b = wx0; acc_load = 1'b1;
      end
      ST_M2: begin
        op_a = OPA_W'(pix[1][{ch, 3'b000} +: CH_W]); op_b = OPB_W'(fx);
        acc_load = 1'b1; acc_add = 1'b1;
      end
      ST_M3: begin
        op_a = OPA_W'(pix[2][{ch, 3'b000} +: CH_W]); op_b = wx0; acc_load = 1'b1;
      end
      ST_M4: begin
        op_a = OPA_W'(pix[3][{ch, 3'b000} +: CH_W]); op_b = OPB_W'(fx);
        acc_load = 1'b1; acc_add = 1'b1;
      end
      ST_M5: begin
        op_a = top; op_b = wy0; acc_load = 1'b1;
      end
      ST_M6: begin
        op_a = bot; op_b = OPB_W'(fy); acc_load = 1'b1; acc_add = 1'b1;
      end
      ST_BL1: begin
        op_a = OPA_W'(small_is_first ? acc_byte : stream_ch);
        op_b = OPB_W'(ratio);
        acc_load = 1'b1;
      end
      ST_BL2: begin
        op_a = OPA_W'(small_is_first ? stream_ch : sample);
        op_b = OPB_W'(ratio_inv);
        acc_load = 1'b1; acc_add = 1'b1;
      end
      default: ;
    endcase
  end

  assign product  = op_a * op_b;
  assign acc_next = (acc_add ? acc : '0) + ACC_W'(product);

  always_ff @(posedge clk) begin
    if (acc_load) begin
      acc <= acc_next;
    end
  end

  // image store, single port
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign mem_we   = in_take && (operation == OP_LOAD);
  assign load_inc = {1'b0, load_address} + 1'b1;

  always_comb begin
    unique case (state)
      ST_B3:   mem_addr = AW'(base1 + AW'(x1));
      ST_R1:   mem_addr = AW'(base1 + AW'(x2));
      ST_R2:   mem_addr = AW'(base2 + AW'(x1));
      ST_R3:   mem_addr = AW'(base2 + AW'(x2));
      default: mem_addr = load_address;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {in_red, in_green, in_blue};
    end
    rdata <= mem[mem_addr];
  end

  // output position
  assign last_col = ({1'b0, out_column} + 1'b1) >= lw;
  assign last_row = ({1'b0, out_row} + 1'b1) >= lh;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load_address <= '0;
      out_column   <= '0;
      out_row      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (mem_we) begin
            load_address <= (load_inc >= product) ? '0 : AW'(load_inc);
          end
          if (in_take && (operation == OP_BLEND)) begin
            state <= ST_SX;
          end
        end
        ST_SX:  state <= ST_SY;
        ST_SY:  state <= ST_YL;
        ST_YL:  state <= ST_B1;
        ST_B1:  state <= ST_B2;
        ST_B2:  state <= ST_B3;
        ST_B3:  state <= ST_R1;
        ST_R1:  state <= ST_R2;
        ST_R2:  state <= ST_R3;
        ST_R3:  state <= ST_R4;
        ST_R4:  state <= ST_M1;
        ST_M1:  state <= ST_M2;
        ST_M2:  state <= ST_M3;
        ST_M3:  state <= ST_M4;
        ST_M4:  state <= ST_M5;
        ST_M5:  state <= ST_M6;
        ST_M6:  state <= ST_BL1;
        ST_BL1: state <= ST_BL2;
        ST_BL2: state <= ST_BL3;
        ST_BL3: state <= (ch == 2'(NUM_CH - 1)) ? ST_DONE : ST_M1;
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
            if (last_col) begin
              out_column <= '0;
              out_row    <= last_row ? '0 : CW'(out_row + 1'b1);
            end else begin
              out_column <= CW'(out_column + 1'b1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          stream_pix <= {in_red, in_green, in_blue};
        end
      end
      ST_SY: begin
        x1 <= x1_c;
        x2 <= x2_c;
        fx <= acc[FRAC_W-1:0];
      end
      ST_YL: begin
        y1 <= y1_c;
        y2 <= y2_c;
        fy <= acc[FRAC_W-1:0];
      end
      ST_B2: base1 <= acc[AW-1:0];
      ST_B3: base2 <= acc[AW-1:0];
      ST_R1: pix[0] <= rdata;
      ST_R2: pix[1] <= rdata;
      ST_R3: pix[2] <= rdata;
      ST_R4: begin
        pix[3] <= rdata;
        ch     <= '0;
      end
      ST_M3: top <= acc[OPA_W-1:0];
      ST_M5: bot <= acc[OPA_W-1:0];
      ST_BL1: sample <= acc_byte;
      ST_BL3: begin
        res[ch] <= acc[CH_W +: CH_W];
        ch      <= ch + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_blue     <= res[0];
          out_green    <= res[1];
          out_red      <= res[2];
          end_of_image <= last_col && last_row;
        end
      end
      default: ;
    endcase
  end

  a_load_addr_step: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (load_address == '0 || load_address == $past(load_address) + 1'b1))
    else $error("load address did not advance or wrap");

  a_eoi_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_col && last_row) |=> (out_column == '0 && out_row == '0))
    else $error("output position not cleared after last pixel");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("finished pixel dropped while output stalled");

endmodule

`default_nettype wire
